### sv/pwc_pkg.sv
// Package for the clamped-term PID block: widths, register indexes and
// reset values shared by the interfaces and the serial arithmetic units.
// No dependencies.
package pwc_pkg;

   localparam int DATA_W    = 32;
   localparam int BOUND_W   = 31;
   localparam int TIMEOUT_W = 16;

   // serial shift-add multiplier, one multiplier bit per cycle
   localparam int MUL_W     = DATA_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int MUL_CNT_W = $clog2(MUL_W);
   localparam int N_MUL     = 3;

   // serial restoring divider, one quotient bit per cycle
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // integral update and output sum widths
   localparam int ACC_W  = DATA_W + 3;
   localparam int TERM_W = DIV_N_W - 16;
   localparam int SUM_W  = TERM_W + 2;

   localparam logic [MUL_W-1:0]     MS_PER_S_MUL = MUL_W'(1000);
   localparam logic [DIV_D_W-1:0]   MS_PER_S_DIV = DIV_D_W'(1000);
   localparam logic [BOUND_W-1:0]   BOUND_RESET   = {BOUND_W{1'b1}};
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_GAIN  = 3'd0,
      CSR_I_GAIN  = 3'd1,
      CSR_D_GAIN  = 3'd2,
      CSR_I_BOUND = 3'd3,
      CSR_D_BOUND = 3'd4,
      CSR_TIMEOUT = 3'd5
   } csr_index_type;

endpackage

### sv/pwc_if.sv
// Handshake channels of the clamped-term PID block: request and response.
// Depends on pwc_pkg.
interface pwc_req_if import pwc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] error_in;
   logic        [DATA_W-1:0] time_ms;
   logic signed [DATA_W-1:0] feed_forward;

   modport source (output valid, error_in, time_ms, feed_forward, input ready);
   modport sink   (input valid, error_in, time_ms, feed_forward, output ready);
endinterface

interface pwc_rsp_if import pwc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] ctrl_out;
   logic                     timed_out;

   modport source (output valid, ctrl_out, timed_out, input ready);
   modport sink   (input valid, ctrl_out, timed_out, output ready);
endinterface

### sv/pwc_ser_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pwc_pkg.
module pwc_ser_mul import pwc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  mcand,
   input  logic [MUL_W-1:0]  mplier,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic                 busy_ff, busy_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]     mcand_ff, mcand_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MUL_W:0]       part;

   assign done    = busy_ff && (cnt_ff == MUL_CNT_W'(MUL_W - 1));
   assign product = prod_ff;

   always_comb begin
      // upper half accumulates, lower half shifts the multiplier out
      part     = {1'b0, prod_ff[PROD_W-1:MUL_W]}
               + ({(MUL_W+1){prod_ff[0]}} & {1'b0, mcand_ff});
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         prod_in  = {{MUL_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         prod_in = {part, prod_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff + MUL_CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

endmodule

### sv/pwc_ser_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on pwc_pkg.
module pwc_ser_div import pwc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W+1:0]   trial;

   assign done     = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_N_W - 1));
   assign quotient = quo_ff;

   always_comb begin
      // quo_ff shifts dividend bits out at the top and quotient bits in below
      trial   = {1'b0, rem_ff, quo_ff[DIV_N_W-1]} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (!trial[DIV_D_W+1]) begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_D_W-2:0], quo_ff[DIV_N_W-1]};
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

### sv/pid_with_clamped_terms.sv
// Channel    Dir  Payload                                 Handshake
// req_port   in   error_in, time_ms, feed_forward         valid/ready
// rsp_port   out  ctrl_out, timed_out                     valid/ready
// csr_*      in   p/i/d gains, bounds, timeout (APB)      psel/penable, pready=1
//
// An item goes from acceptance to the output register through two 33-step
// serial multiplier passes, a 64-step serial divider pass and eight further
// steps. One item is worked on at a time; the next is taken the cycle after
// the previous result has moved to the output register. The output register
// holds a result while rsp ready is low. Synchronous reset restores register
// defaults and clears state.
// Depends on pwc_pkg, pwc_if, pwc_ser_mul and pwc_ser_div.
module pid_with_clamped_terms import pwc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pwc_req_if.sink               req_port,
   pwc_rsp_if.source             rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_PREP  = 12'b0000_0000_0010,
      S_START = 12'b0000_0000_0100,
      S_MUL1  = 12'b0000_0000_1000,
      S_DIVST = 12'b0000_0001_0000,
      S_DIV   = 12'b0000_0010_0000,
      S_UPD   = 12'b0000_0100_0000,
      S_GAIN  = 12'b0000_1000_0000,
      S_MUL2  = 12'b0001_0000_0000,
      S_NEG   = 12'b0010_0000_0000,
      S_ADD   = 12'b0100_0000_0000,
      S_SUM   = 12'b1000_0000_0000
   } state_type;

   function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
      abs32 = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
   endfunction

   state_type state_ff, state_in;

   // configuration
   logic signed [DATA_W-1:0]    p_gain_ff, i_gain_ff, d_gain_ff;
   logic        [BOUND_W-1:0]   ibound_ff, dbound_ff;
   logic        [TIMEOUT_W-1:0] timeout_ff;
   logic                        csr_wr;
   csr_index_type               csr_idx;

   // controller state
   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0] prev_err_ff, prev_err_in;
   logic        [DATA_W-1:0] last_time_ff;

   // per-item working registers
   logic signed [DATA_W-1:0] err_ff;
   logic signed [DATA_W-1:0] ffwd_ff, ffwd_in;
   logic        [DATA_W-1:0] dt_ff;
   logic                     tout_ff, tout_in;
   logic                     dt_zero_ff, dt_zero_in;
   logic signed [DATA_W:0]   diff_ff, diff_in;
   logic signed [DATA_W-1:0] deriv_ff, deriv_in;
   logic [N_MUL-1:0]         neg_ff, neg_in;
   logic [TERM_W-1:0]        term_ff[N_MUL];
   logic [TERM_W-1:0]        term_in[N_MUL];
   logic [DIV_N_W-1:0]       sprod[N_MUL];
   logic [SUM_W-1:0]         s01_ff, s2f_ff, s01_in, s2f_in;
   logic [SUM_W-1:0]         total;
   logic                     ovf;

   // output register
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_force_ff, out_force_in;
   logic                     out_tout_ff, out_tout_in;
   logic                     out_free, req_acc;

   // serial units
   logic [N_MUL-1:0]  mul_start, mul_done;
   logic [MUL_W-1:0]  mul_a[N_MUL];
   logic [MUL_W-1:0]  mul_b[N_MUL];
   logic [PROD_W-1:0] mul_p[N_MUL];
   logic              div_start;
   logic [1:0]        div_done;
   logic [DIV_N_W-1:0] div_q0, div_q1;

   // integral and derivative update
   logic                     q_big;
   logic signed [ACC_W-1:0]  integ_ext, q_ext, acc_sum, bound_ext;
   logic signed [ACC_W-1:0]  acc_clamp;
   logic [BOUND_W-1:0]       dmag;
   logic [DATA_W-1:0]        err_mag, diff_mag_lo;
   logic [MUL_W-1:0]         diff_mag;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      unique case (csr_idx)
         CSR_P_GAIN:  csr_prdata = p_gain_ff;
         CSR_I_GAIN:  csr_prdata = i_gain_ff;
         CSR_D_GAIN:  csr_prdata = d_gain_ff;
         CSR_I_BOUND: csr_prdata = {1'b0, ibound_ff};
         CSR_D_BOUND: csr_prdata = {1'b0, dbound_ff};
         CSR_TIMEOUT: csr_prdata = {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff  <= '0;
         i_gain_ff  <= '0;
         d_gain_ff  <= '0;
         ibound_ff  <= BOUND_RESET;
         dbound_ff  <= BOUND_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_P_GAIN:  p_gain_ff  <= csr_pwdata;
            CSR_I_GAIN:  i_gain_ff  <= csr_pwdata;
            CSR_D_GAIN:  d_gain_ff  <= csr_pwdata;
            CSR_I_BOUND: ibound_ff  <= csr_pwdata[BOUND_W-1:0];
            CSR_D_BOUND: dbound_ff  <= csr_pwdata[BOUND_W-1:0];
            CSR_TIMEOUT: timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshakes ----------------
   assign req_port.ready = (state_ff == S_IDLE);
   assign req_acc        = req_port.valid && req_port.ready;
   assign out_free       = !out_valid_ff || rsp_port.ready;

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.ctrl_out  = out_force_ff;
   assign rsp_port.timed_out = out_tout_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_acc) state_in = S_PREP;
         S_PREP:  state_in = S_START;
         S_START: state_in = S_MUL1;
         S_MUL1:  if (mul_done[0] && mul_done[1]) state_in = S_DIVST;
         S_DIVST: state_in = S_DIV;
         S_DIV:   if (&div_done) state_in = S_UPD;
         S_UPD:   state_in = S_GAIN;
         S_GAIN:  state_in = S_MUL2;
         S_MUL2:  if (&mul_done) state_in = S_NEG;
         S_NEG:   state_in = S_ADD;
         S_ADD:   state_in = S_SUM;
         S_SUM:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- serial units ----------------
   assign err_mag     = abs32(err_ff);
   assign diff_mag_lo = diff_ff[DATA_W] ? (~diff_ff[DATA_W-1:0] + DATA_W'(1))
                                        : diff_ff[DATA_W-1:0];
   // magnitude of a 33-bit difference reaches 2^32 only at the most negative value
   assign diff_mag    = {diff_ff[DATA_W] && (diff_ff[DATA_W-1:0] == '0), diff_mag_lo};

   always_comb begin
      mul_start = '0;
      mul_a[0]  = {1'b0, abs32(p_gain_ff)};
      mul_b[0]  = {1'b0, err_mag};
      mul_a[1]  = {1'b0, abs32(i_gain_ff)};
      mul_b[1]  = {1'b0, abs32(integ_ff)};
      mul_a[2]  = {1'b0, abs32(d_gain_ff)};
      mul_b[2]  = {1'b0, abs32(deriv_ff)};
      if (state_ff == S_START) begin
         mul_start[0] = 1'b1;
         mul_start[1] = 1'b1;
         mul_a[0]     = {1'b0, err_mag};
         mul_b[0]     = {1'b0, dt_ff};
         mul_a[1]     = diff_mag;
         mul_b[1]     = MS_PER_S_MUL;
      end else if (state_ff == S_GAIN) begin
         mul_start = '1;
      end
   end

   for (genvar k = 0; k < N_MUL; k++) begin : g_mul
      pwc_ser_mul u_mul (
         .clock   (clock),
         .reset   (reset),
         .start   (mul_start[k]),
         .mcand   (mul_a[k]),
         .mplier  (mul_b[k]),
         .done    (mul_done[k]),
         .product (mul_p[k])
      );
   end

   assign div_start = (state_ff == S_DIVST);

   // |error| * elapsed / 1000
   pwc_ser_div u_div_int (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[0][DIV_N_W-1:0]),
      .divisor  (MS_PER_S_DIV),
      .done     (div_done[0]),
      .quotient (div_q0)
   );

   // |difference| * 1000 / elapsed
   pwc_ser_div u_div_der (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_p[1][DIV_N_W-1:0]),
      .divisor  (dt_ff),
      .done     (div_done[1]),
      .quotient (div_q1)
   );

   // ---------------- integral and derivative ----------------
   always_comb begin
      q_big     = |div_q0[DIV_N_W-1:DATA_W+1];
      integ_ext = {{(ACC_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff};
      q_ext     = {{(ACC_W-DATA_W-1){1'b0}}, div_q0[DATA_W:0]};
      bound_ext = {{(ACC_W-BOUND_W){1'b0}}, ibound_ff};
      acc_sum   = err_ff[DATA_W-1] ? (integ_ext - q_ext) : (integ_ext + q_ext);
      priority if (q_big) begin
         acc_clamp = err_ff[DATA_W-1] ? -bound_ext : bound_ext;
      end else if (acc_sum > bound_ext) begin
         acc_clamp = bound_ext;
      end else if (acc_sum < -bound_ext) begin
         acc_clamp = -bound_ext;
      end else begin
         acc_clamp = acc_sum;
      end

      // zero elapsed time saturates the derivative by the sign of the difference
      priority if (dt_zero_ff) begin
         dmag = (diff_ff != '0) ? dbound_ff : '0;
      end else if ((|div_q1[DIV_N_W-1:BOUND_W]) || (div_q1[BOUND_W-1:0] > dbound_ff)) begin
         dmag = dbound_ff;
      end else begin
         dmag = div_q1[BOUND_W-1:0];
      end
      deriv_in = diff_ff[DATA_W] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
   end

   // ---------------- state and working registers ----------------
   always_comb begin
      integ_in    = integ_ff;
      prev_err_in = prev_err_ff;
      ffwd_in     = ffwd_ff;
      tout_in     = tout_ff;
      dt_zero_in  = dt_zero_ff;
      diff_in     = diff_ff;
      neg_in      = neg_ff;
      if (state_ff == S_PREP) begin
         tout_in    = dt_ff > DATA_W'(timeout_ff);
         dt_zero_in = (dt_ff == '0);
         diff_in    = {err_ff[DATA_W-1], err_ff}
                    - (tout_in ? '0 : {prev_err_ff[DATA_W-1], prev_err_ff});
         if (tout_in) begin
            integ_in    = '0;
            prev_err_in = '0;
            ffwd_in     = '0;
         end
      end else if (state_ff == S_UPD) begin
         integ_in    = acc_clamp[DATA_W-1:0];
         prev_err_in = err_ff;
      end else if (state_ff == S_GAIN) begin
         neg_in[0] = p_gain_ff[DATA_W-1] ^ err_ff[DATA_W-1];
         neg_in[1] = i_gain_ff[DATA_W-1] ^ integ_ff[DATA_W-1];
         neg_in[2] = d_gain_ff[DATA_W-1] ^ deriv_ff[DATA_W-1];
      end
   end

   // signed products shifted right by 16: the upper bits are the floor
   always_comb begin
      for (int k = 0; k < N_MUL; k++) begin
         sprod[k]   = neg_ff[k] ? (~mul_p[k][DIV_N_W-1:0] + DIV_N_W'(1))
                                : mul_p[k][DIV_N_W-1:0];
         term_in[k] = sprod[k][DIV_N_W-1:16];
      end
      s01_in = {{(SUM_W-TERM_W){term_ff[0][TERM_W-1]}}, term_ff[0]}
             + {{(SUM_W-TERM_W){term_ff[1][TERM_W-1]}}, term_ff[1]};
      s2f_in = {{(SUM_W-TERM_W){term_ff[2][TERM_W-1]}}, term_ff[2]}
             + {{(SUM_W-DATA_W){ffwd_ff[DATA_W-1]}}, ffwd_ff};
      total  = s01_ff + s2f_ff;
      ovf    = !((&total[SUM_W-1:DATA_W-1]) || !(|total[SUM_W-1:DATA_W-1]));
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_force_in = out_force_ff;
      out_tout_in  = out_tout_ff;
      if (rsp_port.valid && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
      if ((state_ff == S_SUM) && out_free) begin
         out_valid_in = 1'b1;
         out_tout_in  = tout_ff;
         if (ovf) begin
            out_force_in = total[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            out_force_in = total[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         last_time_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         out_valid_ff <= out_valid_in;
         if (req_acc) begin
            last_time_ff <= req_port.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         err_ff  <= req_port.error_in;
         ffwd_ff <= req_port.feed_forward;
         dt_ff   <= req_port.time_ms - last_time_ff;
      end else begin
         ffwd_ff <= ffwd_in;
      end
      tout_ff    <= tout_in;
      dt_zero_ff <= dt_zero_in;
      diff_ff    <= diff_in;
      neg_ff     <= neg_in;
      if (state_ff == S_UPD) begin
         deriv_ff <= deriv_in;
      end
      if (state_ff == S_NEG) begin
         for (int k = 0; k < N_MUL; k++) begin
            term_ff[k] <= term_in[k];
         end
      end
      if (state_ff == S_ADD) begin
         s01_ff <= s01_in;
         s2f_ff <= s2f_in;
      end
      out_force_ff <= out_force_in;
      out_tout_ff  <= out_tout_in;
   end

   // ---------------- assertions ----------------
   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL1) |-> (mul_done[0] == mul_done[1]))
      else $error("multipliers out of step");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_done[0] == div_done[1]))
      else $error("dividers out of step");

   a_timeout_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_START) && tout_ff) |-> ((integ_ff == '0) && (prev_err_ff == '0)))
      else $error("timeout did not clear controller state");

   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAIN) |-> ((integ_ff <= $signed({1'b0, ibound_ff}))
                                && (integ_ff >= -$signed({1'b0, ibound_ff}))))
      else $error("integral outside its bound");

   a_deriv_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAIN) |-> ((deriv_ff <= $signed({1'b0, dbound_ff}))
                                && (deriv_ff >= -$signed({1'b0, dbound_ff}))))
      else $error("derivative outside its bound");

   a_accept_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> ((state_ff == S_PREP) && (last_time_ff == $past(req_port.time_ms))))
      else $error("timestamp not captured on accept");

endmodule
